@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define KVC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never occurs outside reset.
`define KVC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ rtl/lru_kvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
package lru_kvc_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Width and reset value of the capacity register
  localparam int          CFG_W     = 5;
  localparam logic [4:0]  CFG_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
//
// One command (get or put) is taken on each clock edge where start is high;
// busy stays low, so a new beat may follow in every cycle. The command is
// held in an input register, and in the following cycle all stored keys are
// compared at once, the recency ranks are updated and the result is
// captured in a result register. The result therefore appears on done_o
// for exactly one cycle; the receiver cannot stall it and must take it
// then. Sustained rate is one command per cycle, set by the single
// compare-and-update pass over the entry registers.
// Recency is a rank per entry, 0 being the most recent. A get miss returns
// -1, a put returns 0 as read value. When a put inserts a new key into a
// full cache the least recent entry is evicted and its key reported.
// Writing the capacity register (through cfg_valid_i/cfg_ready_o) empties
// the cache at once; a value of 0 acts as 1 and one above CAPACITY acts as
// CAPACITY. cfg_ready_o is low while a command waits in the input register.
module lru_key_value_cache
  import lru_kvc_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  // capacity register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_W-1:0]             cfg_data_i,
  // result
  output logic                         done_o,
  output logic                         hit_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic                         evicted_o,
  output logic [KEY_BITS-1:0]          evicted_key_o
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int RANK_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Input register
  logic                  in_valid_q;
  cmd_e                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // Entry state
  logic [CAPACITY-1:0]   valid_q, valid_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CFG_W-1:0]      cap_q;
  logic [KEY_BITS-1:0]   key_mem_q  [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem_q  [CAPACITY];
  logic [RANK_W-1:0]     rank_q     [CAPACITY];
  logic [RANK_W-1:0]     rank_d     [CAPACITY];

  // Result register
  logic                  done_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] rd_q;
  logic                  ev_q;
  logic [KEY_BITS-1:0]   evk_q;

  // Lookup and update logic
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   victim_oh;
  logic [CAPACITY-1:0]   free_oh;
  logic [CAPACITY-1:0]   ins_oh;
  logic                  found;
  logic                  is_put;
  logic                  full;
  logic                  do_evict;
  logic                  do_insert;
  logic [VALUE_BITS-1:0] hit_val;
  logic [KEY_BITS-1:0]   victim_key;
  logic [RANK_W-1:0]     found_rank;
  logic [RANK_W-1:0]     last_rank;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  cfg_we;

  assign busy        = 1'b0;
  assign cfg_ready_o = !in_valid_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    // Clamp capacity in use to 1..CAPACITY
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
    full      = CMP_W'(count_q) >= cap_eff;
    last_rank = RANK_W'(count_q - CNT_W'(1));
    is_put    = (cmd_q == CMD_PUT);

    // Parallel compare against every entry
    hit_val    = '0;
    victim_key = '0;
    found_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]     = valid_q[i] && (key_mem_q[i] == key_q);
      victim_oh[i] = valid_q[i] && (rank_q[i] == last_rank);
      if (match[i]) begin
        hit_val    = hit_val | val_mem_q[i];
        found_rank = found_rank | rank_q[i];
      end
      if (victim_oh[i]) begin
        victim_key = victim_key | key_mem_q[i];
      end
    end
    found = |match;

    // Lowest free slot
    free_oh = ~valid_q & (valid_q + CAPACITY'(1));

    do_insert = in_valid_q && is_put && !found;
    do_evict  = do_insert && full;
    ins_oh    = do_evict ? victim_oh : free_oh;

    // Next valid flags and entry count
    valid_d = valid_q;
    count_d = count_q;
    if (do_insert) begin
      valid_d = valid_q | ins_oh;
      if (!do_evict) begin
        count_d = count_q + CNT_W'(1);
      end
    end

    // Next recency ranks: promote on a hit, age all on an insert
    for (int i = 0; i < CAPACITY; i++) begin
      rank_d[i] = rank_q[i];
      if (found) begin
        if (match[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && rank_q[i] < found_rank) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end else if (do_insert) begin
        if (ins_oh[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
      valid_q    <= '0;
      count_q    <= '0;
      cap_q      <= CFG_RESET;
    end else begin
      in_valid_q <= start && !busy;
      done_q     <= in_valid_q;
      if (cfg_we) begin
        // Capacity change empties the cache
        cap_q   <= cfg_data_i;
        valid_q <= '0;
        count_q <= '0;
      end else if (in_valid_q) begin
        valid_q <= valid_d;
        count_q <= count_d;
      end
    end
  end

  // Input and result payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= key_i;
      val_q <= value_i;
    end
    if (in_valid_q) begin
      hit_q <= found;
      if (is_put) begin
        rd_q <= '0;
      end else if (found) begin
        rd_q <= hit_val;
      end else begin
        rd_q <= '1;
      end
      ev_q  <= do_evict;
      evk_q <= do_evict ? victim_key : '0;
    end
  end

  // Entry payload: keys, values and ranks
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= rank_d[i];
        if (do_insert && ins_oh[i]) begin
          key_mem_q[i] <= key_q;
          val_mem_q[i] <= val_q;
        end else if (is_put && match[i]) begin
          val_mem_q[i] <= val_q;
        end
      end
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

endmodule

@@ rtl/lru_kvc_chk.sv @@
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "assert_macros.svh"

module lru_kvc_chk
  import lru_kvc_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  command_i,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic                  done_o,
  input logic                  hit_o,
  input logic [VALUE_BITS-1:0] read_value_o,
  input logic                  evicted_o,
  input logic [KEY_BITS-1:0]   evicted_key_o
);

  // Every accepted beat yields a result on done_o
  `KVC_ASSERT(a_result_follows, clk_i, rst_ni, (start && !busy) |-> ##2 done_o, "lost result")

  // No result on done_o without an earlier accepted beat
  `KVC_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start && !busy, 2), "extra result")

  // A get miss reads back all ones
  `KVC_ASSERT(a_get_miss, clk_i, rst_ni, (done_o && !hit_o && ($past(command_i, 2) == CMD_GET)) |-> (read_value_o == '1), "bad miss value")

  // Eviction only on a put of a new key; the flag holds between results
  `KVC_NEVER(a_evict_cause, clk_i, rst_ni, done_o && evicted_o && (hit_o || ($past(command_i, 2) != CMD_PUT)), "bad eviction")

  // The evicted key is zero unless an entry was evicted
  `KVC_NEVER(a_evk_zero, clk_i, rst_ni, done_o && !evicted_o && (evicted_key_o != '0), "stray evicted key")

endmodule

bind lru_key_value_cache lru_kvc_chk #(
  .KEY_BITS  (KEY_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_lru_kvc_chk (.*);

@@ bench/lru_key_value_cache_tb.sv @@
// Self-checking bench for the LRU key-value cache: directed and random gets and puts.
module lru_key_value_cache_tb;
  import lru_kvc_pkg::*;

  localparam int SLOTS      = CAPACITY_DEF;
  localparam int KW         = KEY_BITS_DEF;
  localparam int VW         = VALUE_BITS_DEF;
  localparam int POOL_SIZE  = 24;
  localparam int STALL_STOP = 2000;   // cycles with no beat before giving up

  typedef struct {
    cmd_e                 cmd;
    logic [KW-1:0]        key;
    logic signed [VW-1:0] value;
  } cache_access_t;

  typedef struct {
    logic                 hit;
    logic signed [VW-1:0] read_value;
    logic                 evicted;
    logic [KW-1:0]        evicted_key;
  } access_outcome_t;

  // DUT connections; every input holds a known value from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic                 command_i   = 1'b0;
  logic [KW-1:0]        key_i       = '0;
  logic signed [VW-1:0] value_i     = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 done_o;
  logic                 hit_o;
  logic signed [VW-1:0] read_value_o;
  logic                 evicted_o;
  logic [KW-1:0]        evicted_key_o;

  lru_key_value_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Mirror of the cache contents. Recency is a rank per line, 0 being the
  // most recent; line_count lines are valid at any time.
  // ---------------------------------------------------------------------
  logic             line_valid [SLOTS];
  logic [KW-1:0]    line_key   [SLOTS];
  logic [VW-1:0]    line_value [SLOTS];
  logic [3:0]       line_rank  [SLOTS];
  logic [4:0]       line_count;
  logic [CFG_W-1:0] capacity_reg;

  // Bench bookkeeping
  cache_access_t    accesses_to_send [$];
  logic [CFG_W-1:0] capacity_writes  [$];
  access_outcome_t  outcomes_due     [$];
  cache_access_t    next_access;
  logic [KW-1:0]    key_pool [POOL_SIZE];
  int               idle_pct;
  int               accesses_queued;
  int               accesses_taken;
  int               outcomes_checked;
  int               capacity_writes_taken;
  int               error_count;
  int               quiet_cycles;

  function automatic void empty_cache();
    for (int i = 0; i < SLOTS; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_value[i] = '0;
      line_rank[i]  = '0;
    end
    line_count = '0;
  endfunction

  // Zero acts as one and anything above the table size as the table size.
  function automatic logic [4:0] usable_lines(input logic [CFG_W-1:0] cap);
    if (cap == '0) return 5'd1;
    if (cap > 5'(SLOTS)) return 5'(SLOTS);
    return cap;
  endfunction

  // Make a line the most recent; lines that were more recent age by one.
  function automatic void promote_line(input int s);
    logic [3:0] old_rank;
    old_rank = line_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (line_valid[i] && line_rank[i] < old_rank) line_rank[i] = line_rank[i] + 4'd1;
    line_rank[s] = '0;
  endfunction

  // Apply one get or put to the mirror and return what the cache must say.
  function automatic access_outcome_t apply_access(input cache_access_t acc);
    access_outcome_t res;
    int              found;
    int              slot;
    res.hit         = 1'b0;
    res.read_value  = '0;
    res.evicted     = 1'b0;
    res.evicted_key = '0;
    found = -1;
    slot  = -1;
    for (int i = 0; i < SLOTS; i++)
      if (line_valid[i] && line_key[i] == acc.key) found = i;
    if (acc.cmd == CMD_GET) begin
      if (found >= 0) begin
        res.hit        = 1'b1;
        res.read_value = line_value[found];
        promote_line(found);
      end else begin
        res.read_value = -1;
      end
    end else if (found >= 0) begin
      res.hit           = 1'b1;
      line_value[found] = acc.value;
      promote_line(found);
    end else begin
      // Full: evict the least recent line and reuse its slot
      if (line_count >= usable_lines(capacity_reg)) begin
        for (int i = 0; i < SLOTS; i++)
          if (line_valid[i] && 5'(line_rank[i]) == line_count - 5'd1) slot = i;
        if (slot >= 0) begin
          res.evicted      = 1'b1;
          res.evicted_key  = line_key[slot];
          line_valid[slot] = 1'b0;
          line_count       = line_count - 5'd1;
        end
      end
      // Otherwise take the lowest free slot
      if (slot < 0)
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!line_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (line_valid[i]) line_rank[i] = line_rank[i] + 4'd1;
        line_valid[slot] = 1'b1;
        line_key[slot]   = acc.key;
        line_value[slot] = acc.value;
        line_rank[slot]  = '0;
        line_count       = line_count + 5'd1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [KW-1:0] got,
                                 input logic [KW-1:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: present queued accesses and capacity writes. A beat on either
  // channel is taken at the edge where its valid is high and the block is
  // ready; the mirror is updated at that same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_reg = cfg_data_i;
        empty_cache();
        capacity_writes_taken++;
      end
      if (start && !busy) begin
        next_access.cmd   = cmd_e'(command_i);
        next_access.key   = key_i;
        next_access.value = value_i;
        outcomes_due.push_back(apply_access(next_access));
        accesses_taken++;
      end

      // Command channel: hold a beat the block has not taken yet
      if (start && busy) begin
      end else if (accesses_to_send.size() > 0 && !cfg_valid_i &&
                   $urandom_range(99) >= idle_pct) begin
        next_access = accesses_to_send.pop_front();
        start     <= 1'b1;
        command_i <= next_access.cmd;
        key_i     <= next_access.key;
        value_i   <= next_access.value;
      end else begin
        start <= 1'b0;
      end

      // Capacity channel: one write at a time, dropped once taken
      if (cfg_valid_i && !cfg_ready_o) begin
      end else if (!cfg_valid_i && capacity_writes.size() > 0 && !start) begin
        cfg_valid_i <= 1'b1;
        cfg_data_i  <= capacity_writes.pop_front();
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every done_o cycle carries one result, compared field by field
  // with the oldest outstanding expectation. Also watch for a stuck run.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    access_outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, key", evicted_key_o, '0);
        end else begin
          want = outcomes_due.pop_front();
          outcomes_checked++;
          if (hit_o !== want.hit)
            report_mismatch("hit", KW'(hit_o), KW'(want.hit));
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", read_value_o, want.read_value);
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", KW'(evicted_o), KW'(want.evicted));
          if (evicted_key_o !== want.evicted_key)
            report_mismatch("evicted_key", evicted_key_o, want.evicted_key);
        end
      end
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_STOP) begin
          $display("timeout: no beat for %0d cycles", STALL_STOP);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_access(input cmd_e cmd, input logic [KW-1:0] key,
                              input logic [VW-1:0] value);
    cache_access_t acc;
    acc.cmd   = cmd;
    acc.key   = key;
    acc.value = value;
    accesses_to_send.push_back(acc);
    accesses_queued++;
  endtask

  // Wait until every queued access has been taken and answered.
  task automatic wait_idle();
    while (accesses_taken != accesses_queued || outcomes_checked != accesses_taken ||
           accesses_to_send.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    int target;
    wait_idle();
    target = capacity_writes_taken + 1;
    capacity_writes.push_back(cap);
    while (capacity_writes_taken != target) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Random gets and puts over a key pool a little larger than the capacity,
  // so hits, updates and evictions all occur; a few keys are fully random.
  task automatic queue_random_accesses(input int n, input logic [CFG_W-1:0] cap);
    int   span;
    logic [KW-1:0] key;
    span = int'(usable_lines(cap));
    span = span + span / 2 + 2;
    if (span > POOL_SIZE) span = POOL_SIZE;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) key = $urandom;
      else key = key_pool[$urandom_range(span - 1)];
      queue_access(($urandom_range(99) < 55) ? CMD_PUT : CMD_GET, key, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] caps [8];
    caps = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd17, 5'd8, 5'd2, 5'd5};
    idle_pct              = 0;
    accesses_queued       = 0;
    accesses_taken        = 0;
    outcomes_checked      = 0;
    capacity_writes_taken = 0;
    error_count           = 0;
    quiet_cycles          = 0;
    capacity_reg          = CFG_RESET;
    empty_cache();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: miss on an empty cache, key and value extremes, update
    queue_access(CMD_GET, '0, '0);
    queue_access(CMD_PUT, '0, 32'h8000_0000);
    queue_access(CMD_PUT, '1, 32'h7fff_ffff);
    queue_access(CMD_GET, '0, '1);
    queue_access(CMD_GET, '1, '0);
    queue_access(CMD_PUT, '0, '0);
    queue_access(CMD_GET, '0, '0);
    queue_access(CMD_GET, 32'd5, '0);

    // Zero capacity acts as one line: every new key evicts the last
    write_capacity(5'd0);
    queue_access(CMD_PUT, 32'd1, 32'd11);
    queue_access(CMD_PUT, 32'd2, 32'd22);
    queue_access(CMD_GET, 32'd1, '0);
    queue_access(CMD_GET, 32'd2, '0);
    queue_access(CMD_PUT, 32'd2, 32'd33);

    // Two lines: a get promotes, so the other line is the victim
    write_capacity(5'd2);
    queue_access(CMD_PUT, 32'd10, 32'd100);
    queue_access(CMD_PUT, 32'd11, 32'd110);
    queue_access(CMD_GET, 32'd10, '0);
    queue_access(CMD_PUT, 32'd12, 32'd120);
    queue_access(CMD_GET, 32'd11, '0);

    // Random phases over several capacities, rotating the sender idle rate
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 6;
      endcase
      queue_random_accesses(48, caps[p]);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (outcomes_due.size() != 0)
      report_mismatch("results still outstanding", KW'(outcomes_due.size()), '0);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
